/* rtl/core/wmcr_pkg.sv */
// Shared types and constants of the Wiegand multi-channel receiver.
// Used by the modules under rtl/core except wmcr_ram; depends on nothing.
`default_nettype none

package wmcr_pkg;

   localparam int TIME_W      = 32;
   localparam int DOOR_W      = 8;
   localparam int TAG_W       = 24;
   localparam int NUM_DOORS   = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 72;

   // configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GAP_TIMEOUT = 3'd0,
      CSR_DOOR_CH0    = 3'd1,
      CSR_DOOR_CH1    = 3'd2,
      CSR_DOOR_CH2    = 3'd3,
      CSR_DOOR_CH3    = 3'd4
   } csr_index_type;

   localparam logic [TIME_W-1:0] GAP_TIMEOUT_RESET = 32'd100000;
   localparam logic [DOOR_W-1:0] DOOR_CH0_RESET    = 8'd13;
   localparam logic [DOOR_W-1:0] DOOR_CH1_RESET    = 8'd11;
   localparam logic [DOOR_W-1:0] DOOR_CH2_RESET    = 8'd14;
   localparam logic [DOOR_W-1:0] DOOR_CH3_RESET    = 8'd12;

   // status of one channel update, frame stage to top level
   typedef struct packed {
      logic take;   // a bit was shifted in
      logic done;   // the frame completed with this bit
   } upd_status_type;

endpackage

`default_nettype wire

/* rtl/core/wmcr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Standalone; no package dependency.
`default_nettype none

module wmcr_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 4,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/wmcr_frame_update.sv */
// Per-channel frame assembly: gap check, bit shift-in, completion and frame time.
// Depends on wmcr_pkg.
`default_nettype none

module wmcr_frame_update #(
   parameter int FRAME_BITS = 26,
   parameter int CNT_W      = 5
) (
   input  wire logic                          take,
   input  wire logic                          bit_in,
   input  wire logic [wmcr_pkg::TIME_W-1:0]   now,
   input  wire logic [wmcr_pkg::TIME_W-1:0]   pulse_len,
   input  wire logic [wmcr_pkg::TIME_W-1:0]   gap_timeout,
   input  wire logic                          active_rd,
   input  wire logic [CNT_W-1:0]              count_rd,
   input  wire logic [FRAME_BITS-1:0]         shift_rd,
   input  wire logic [wmcr_pkg::TIME_W-1:0]   first_time_rd,
   input  wire logic [wmcr_pkg::TIME_W-1:0]   first_pulse_rd,
   input  wire logic [wmcr_pkg::TIME_W-1:0]   last_time_rd,
   output logic                               active_wr,
   output logic      [CNT_W-1:0]              count_wr,
   output logic      [FRAME_BITS-1:0]         shift_wr,
   output logic      [wmcr_pkg::TIME_W-1:0]   first_time_wr,
   output logic      [wmcr_pkg::TIME_W-1:0]   first_pulse_wr,
   output logic      [wmcr_pkg::TIME_W-1:0]   last_time_wr,
   output logic      [wmcr_pkg::TAG_W-1:0]    tag,
   output logic      [wmcr_pkg::TIME_W-1:0]   frame_time,
   output wmcr_pkg::upd_status_type           status
);

   localparam logic [CNT_W-1:0] TOP_BIT   = CNT_W'(FRAME_BITS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(FRAME_BITS);

   logic                        new_frame;
   logic [CNT_W-1:0]            cnt0;
   logic [CNT_W-1:0]            cnt1;
   logic [FRAME_BITS-1:0]       sv0;
   logic [FRAME_BITS-1:0]       sv1;
   logic [wmcr_pkg::TIME_W-1:0] since_last;
   logic [wmcr_pkg::TIME_W-1:0] fbt;
   logic [wmcr_pkg::TIME_W-1:0] fpl;
   logic [31:0]                 sv_wide;
   logic                        done;

   always_comb begin
      since_last = now - last_time_rd;
      new_frame  = !active_rd || (since_last > gap_timeout);
      cnt0       = new_frame ? '0 : count_rd;
      if (cnt0 >= FULL_CNT) begin
         cnt0 = '0;
      end
      sv0   = new_frame ? '0 : shift_rd;
      fbt   = new_frame ? now : first_time_rd;
      fpl   = (cnt0 == '0) ? pulse_len : first_pulse_rd;
      // MSB first
      sv1   = sv0 | (FRAME_BITS'(bit_in) << (TOP_BIT - cnt0));
      cnt1  = cnt0 + CNT_W'(1);
      done  = (cnt1 == FULL_CNT);

      sv_wide    = 32'(sv1);
      tag        = sv_wide[wmcr_pkg::TAG_W:1];
      frame_time = now - fbt + fpl;

      if (take) begin
         active_wr      = !done;
         count_wr       = done ? '0 : cnt1;
         shift_wr       = sv1;
         first_time_wr  = fbt;
         first_pulse_wr = fpl;
         last_time_wr   = now;
      end else begin
         active_wr      = active_rd;
         count_wr       = count_rd;
         shift_wr       = shift_rd;
         first_time_wr  = first_time_rd;
         first_pulse_wr = first_pulse_rd;
         last_time_wr   = last_time_rd;
      end

      status.take = take;
      status.done = take && done;
   end

endmodule

`default_nettype wire

/* rtl/core/wiegand_multi_channel_receiver.sv */
// Wiegand multi-channel receiver, top level. A completing word is registered into stage 1
// with its state read, then updated and loaded into the output register that drives rsp_.
// Takes one word per cycle unless a bit waits on a full output register; line and channel
// state sit in registered-read RAMs, back-to-back hits on one entry are forwarded from the last write.
// Reset is synchronous; per-entry valid bits make unwritten entries read as idle.
// Depends on wmcr_pkg, wmcr_ram, wmcr_frame_update.
`default_nettype none

module wiegand_multi_channel_receiver #(
   parameter int NUM_CHANNELS = 4,
   parameter int FRAME_BITS   = 26
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // [1:0] channel_index, [2] line_select, [3] line_level, [35:4] now_us
   input  wire logic [wmcr_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // [1:0] out_channel, [9:2] door, [33:10] tag, [65:34] frame_time_us
   output logic      [wmcr_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   input  wire logic                                  csr_we,
   input  wire logic [wmcr_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire logic [wmcr_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int TW         = wmcr_pkg::TIME_W;
   localparam int NUM_LINES  = 2 * NUM_CHANNELS;
   localparam int CA_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int LA_W       = $clog2(NUM_LINES);
   localparam int CNT_W      = $clog2(FRAME_BITS + 1);
   localparam int LINE_W     = 1 + TW;
   localparam int CHAN_W     = 1 + CNT_W + FRAME_BITS + 3 * TW;
   localparam logic [LINE_W-1:0] LINE_IDLE = {1'b1, {TW{1'b0}}};

   // ---------------- configuration ----------------
   logic [TW-1:0]                 gap_ff;
   logic [wmcr_pkg::DOOR_W-1:0]   door_ff [wmcr_pkg::NUM_DOORS];

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff     <= wmcr_pkg::GAP_TIMEOUT_RESET;
         door_ff[0] <= wmcr_pkg::DOOR_CH0_RESET;
         door_ff[1] <= wmcr_pkg::DOOR_CH1_RESET;
         door_ff[2] <= wmcr_pkg::DOOR_CH2_RESET;
         door_ff[3] <= wmcr_pkg::DOOR_CH3_RESET;
      end else if (csr_we) begin
         unique case (wmcr_pkg::csr_index_type'(csr_addr))
            wmcr_pkg::CSR_GAP_TIMEOUT: gap_ff     <= csr_wdata;
            wmcr_pkg::CSR_DOOR_CH0:    door_ff[0] <= csr_wdata[wmcr_pkg::DOOR_W-1:0];
            wmcr_pkg::CSR_DOOR_CH1:    door_ff[1] <= csr_wdata[wmcr_pkg::DOOR_W-1:0];
            wmcr_pkg::CSR_DOOR_CH2:    door_ff[2] <= csr_wdata[wmcr_pkg::DOOR_W-1:0];
            wmcr_pkg::CSR_DOOR_CH3:    door_ff[3] <= csr_wdata[wmcr_pkg::DOOR_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- input decode ----------------
   logic [1:0]      in_ch;
   logic            in_sel;
   logic [CA_W-1:0] in_caddr;
   logic [LA_W-1:0] in_laddr;
   logic            accept;

   assign in_ch    = req_tdata[1:0];
   assign in_sel   = req_tdata[2];
   assign in_caddr = CA_W'(in_ch);
   assign in_laddr = LA_W'({in_caddr, in_sel});
   assign accept   = req_tvalid && req_tready;

   // ---------------- stage 1 registers ----------------
   logic            s1_valid_ff, s1_valid_in;
   logic            s1_inrange_ff;
   logic [1:0]      s1_ch_ff;
   logic            s1_sel_ff;
   logic            s1_level_ff;
   logic [TW-1:0]   s1_now_ff;
   logic [CA_W-1:0] s1_caddr_ff;
   logic [LA_W-1:0] s1_laddr_ff;

   // ---------------- state memories ----------------
   logic              line_we, chan_we;
   logic [LINE_W-1:0] line_rd, line_wd;
   logic [CHAN_W-1:0] chan_rd, chan_wd;

   wmcr_ram #(.WIDTH(LINE_W), .DEPTH(NUM_LINES), .ADDR_W(LA_W)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (s1_laddr_ff),
      .wr_data (line_wd),
      .rd_en   (accept),
      .rd_addr (in_laddr),
      .rd_data (line_rd)
   );

   wmcr_ram #(.WIDTH(CHAN_W), .DEPTH(NUM_CHANNELS), .ADDR_W(CA_W)) u_chan_ram (
      .clock   (clock),
      .wr_en   (chan_we),
      .wr_addr (s1_caddr_ff),
      .wr_data (chan_wd),
      .rd_en   (accept),
      .rd_addr (in_caddr),
      .rd_data (chan_rd)
   );

   // valid bits and last-write forwarding
   logic [NUM_LINES-1:0]    line_vld_ff, line_vld_in;
   logic [NUM_CHANNELS-1:0] chan_vld_ff, chan_vld_in;
   logic                    lfw_vld_ff, cfw_vld_ff;
   logic [LA_W-1:0]         lfw_addr_ff;
   logic [CA_W-1:0]         cfw_addr_ff;
   logic [LINE_W-1:0]       lfw_data_ff;
   logic [CHAN_W-1:0]       cfw_data_ff;

   logic [LINE_W-1:0] line_cur;
   logic [CHAN_W-1:0] chan_cur;

   always_comb begin
      if (lfw_vld_ff && lfw_addr_ff == s1_laddr_ff) begin
         line_cur = lfw_data_ff;
      end else if (line_vld_ff[s1_laddr_ff]) begin
         line_cur = line_rd;
      end else begin
         line_cur = LINE_IDLE;
      end
      if (cfw_vld_ff && cfw_addr_ff == s1_caddr_ff) begin
         chan_cur = cfw_data_ff;
      end else if (chan_vld_ff[s1_caddr_ff]) begin
         chan_cur = chan_rd;
      end else begin
         chan_cur = '0;
      end
   end

   // ---------------- stage 1 update ----------------
   logic          last_level;
   logic [TW-1:0] low_start;
   logic          s1_rise;
   logic          s1_adv;
   logic          rsp_free;
   logic          s1_write;

   assign last_level = line_cur[LINE_W-1];
   assign low_start  = line_cur[TW-1:0];
   assign s1_rise    = s1_inrange_ff && s1_level_ff && !last_level;
   assign rsp_free   = !rsp_tvalid || rsp_tready;
   assign s1_adv     = !s1_valid_ff || !s1_rise || rsp_free;
   assign req_tready = s1_adv;
   assign s1_write   = s1_valid_ff && s1_adv && s1_inrange_ff;

   always_comb begin
      line_wd = {s1_level_ff, low_start};
      // falling edge marks the start of the low pulse
      if (!s1_level_ff && last_level) begin
         line_wd[TW-1:0] = s1_now_ff;
      end
   end

   logic                     act_rd, act_wr;
   logic [CNT_W-1:0]         cnt_rd, cnt_wr;
   logic [FRAME_BITS-1:0]    sv_rd, sv_wr;
   logic [TW-1:0]            fbt_rd, fbt_wr, fpl_rd, fpl_wr, lbt_rd, lbt_wr;
   logic [wmcr_pkg::TAG_W-1:0] upd_tag;
   logic [TW-1:0]            upd_time;
   wmcr_pkg::upd_status_type upd_status;

   assign {act_rd, cnt_rd, sv_rd, fbt_rd, fpl_rd, lbt_rd} = chan_cur;
   assign chan_wd = {act_wr, cnt_wr, sv_wr, fbt_wr, fpl_wr, lbt_wr};

   wmcr_frame_update #(.FRAME_BITS(FRAME_BITS), .CNT_W(CNT_W)) u_frame (
      .take           (s1_rise),
      .bit_in         (s1_sel_ff),
      .now            (s1_now_ff),
      .pulse_len      (s1_now_ff - low_start),
      .gap_timeout    (gap_ff),
      .active_rd      (act_rd),
      .count_rd       (cnt_rd),
      .shift_rd       (sv_rd),
      .first_time_rd  (fbt_rd),
      .first_pulse_rd (fpl_rd),
      .last_time_rd   (lbt_rd),
      .active_wr      (act_wr),
      .count_wr       (cnt_wr),
      .shift_wr       (sv_wr),
      .first_time_wr  (fbt_wr),
      .first_pulse_wr (fpl_wr),
      .last_time_wr   (lbt_wr),
      .tag            (upd_tag),
      .frame_time     (upd_time),
      .status         (upd_status)
   );

   assign line_we = s1_write;
   assign chan_we = s1_write && upd_status.take;

   always_comb begin
      line_vld_in = line_vld_ff;
      chan_vld_in = chan_vld_ff;
      if (line_we) begin
         line_vld_in[s1_laddr_ff] = 1'b1;
      end
      if (chan_we) begin
         chan_vld_in[s1_caddr_ff] = 1'b1;
      end
      s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         line_vld_ff <= '0;
         chan_vld_ff <= '0;
         lfw_vld_ff  <= 1'b0;
         cfw_vld_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         line_vld_ff <= line_vld_in;
         chan_vld_ff <= chan_vld_in;
         if (line_we) begin
            lfw_vld_ff <= 1'b1;
         end
         if (chan_we) begin
            cfw_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_inrange_ff <= (32'(in_ch) < NUM_CHANNELS);
         s1_ch_ff      <= in_ch;
         s1_sel_ff     <= in_sel;
         s1_level_ff   <= req_tdata[3];
         s1_now_ff     <= req_tdata[35:4];
         s1_caddr_ff   <= in_caddr;
         s1_laddr_ff   <= in_laddr;
      end
      if (line_we) begin
         lfw_addr_ff <= s1_laddr_ff;
         lfw_data_ff <= line_wd;
      end
      if (chan_we) begin
         cfw_addr_ff <= s1_caddr_ff;
         cfw_data_ff <= chan_wd;
      end
   end

   // ---------------- output register ----------------
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [wmcr_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic                          rsp_load;

   assign rsp_load = s1_write && upd_status.done;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {6'd0, upd_time, upd_tag, door_ff[s1_ch_ff], s1_ch_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // stage 1 only holds when a bit waits on a full output register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> (s1_rise && rsp_tvalid && !rsp_tready))
      else $error("stage 1 stalled without a blocked result");

   // a completed frame always comes from a shifted-in bit
   a_done_take: assert property (@(posedge clock) disable iff (reset)
      upd_status.done |-> upd_status.take)
      else $error("frame done without a bit");

   // stored bit count stays below the frame length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      chan_we |-> (32'(cnt_wr) < FRAME_BITS))
      else $error("bit count out of range");

   // a loaded result is presented on the next cycle
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_tvalid)
      else $error("result lost");
`endif

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the four-channel Wiegand receiver: line-change words in, card reports out.
// Holds its own frame decoder; needs only wmcr_pkg and the receiver top level.
`timescale 1ns / 1ps

module testbench;

   localparam int NUM_CHANNELS = 4;
   localparam int FRAME_BITS   = 26;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_EVENTS = 330;

   typedef struct packed {
      logic [31:0] now_us;
      logic        line_level;
      logic        line_select;
      logic [1:0]  channel_index;
   } line_event_type;

   typedef struct packed {
      logic [31:0] frame_time_us;
      logic [23:0] tag;
      logic [7:0]  door;
      logic [1:0]  out_channel;
   } card_report_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic [wmcr_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [wmcr_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic                             csr_we = 1'b0;
   logic [wmcr_pkg::CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [wmcr_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   wiegand_multi_channel_receiver #(
      .NUM_CHANNELS(NUM_CHANNELS),
      .FRAME_BITS  (FRAME_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // decoder copy of the receiver state
   logic [31:0] gap_timeout;
   logic [7:0]  door_id[NUM_CHANNELS];
   logic        seen_level[2*NUM_CHANNELS];
   logic [31:0] low_since[2*NUM_CHANNELS];
   logic        in_frame[NUM_CHANNELS];
   int          bits_in[NUM_CHANNELS];
   logic [FRAME_BITS-1:0] frame_bits[NUM_CHANNELS];
   logic [31:0] first_bit_at[NUM_CHANNELS];
   logic [31:0] last_bit_at[NUM_CHANNELS];
   logic [31:0] first_pulse[NUM_CHANNELS];

   // stimulus side
   bit          gen_level[2*NUM_CHANNELS];
   logic [31:0] gen_time[NUM_CHANNELS];
   line_event_type staged[NUM_CHANNELS][$];
   line_event_type line_events[$];
   card_report_type pending_reports[$];

   int  phase_events = 0;
   int  events_queued = 0;
   int  events_accepted = 0;
   int  errors = 0;
   int  cycle_count = 0;
   bit  req_fired = 1'b0;
   int  req_idle = 0, req_quiet = 0;
   int  rsp_hold = 0, rsp_quiet = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("wiegand_multi_channel_receiver verification failed");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, and now and then a stretch with none
   function automatic int idle_len(inout int quiet);
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         quiet = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic reset_decoder();
      gap_timeout = wmcr_pkg::GAP_TIMEOUT_RESET;
      door_id[0] = wmcr_pkg::DOOR_CH0_RESET;
      door_id[1] = wmcr_pkg::DOOR_CH1_RESET;
      door_id[2] = wmcr_pkg::DOOR_CH2_RESET;
      door_id[3] = wmcr_pkg::DOOR_CH3_RESET;
      for (int i = 0; i < 2*NUM_CHANNELS; i++) begin
         seen_level[i] = 1'b1;
         low_since[i] = '0;
         gen_level[i] = 1'b1;
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         in_frame[c] = 1'b0;
         bits_in[c] = 0;
         frame_bits[c] = '0;
         first_bit_at[c] = '0;
         last_bit_at[c] = '0;
         first_pulse[c] = '0;
         gen_time[c] = '0;
      end
   endtask

   task automatic decode_line_event(input line_event_type ev);
      int              c;
      int              li;
      logic [31:0]     pulse;
      logic [31:0]     since_last;
      card_report_type rep;
      c = ev.channel_index;
      li = 2*c + ev.line_select;
      if (!ev.line_level && seen_level[li])
         low_since[li] = ev.now_us;
      if (ev.line_level && !seen_level[li]) begin
         pulse = ev.now_us - low_since[li];
         since_last = ev.now_us - last_bit_at[c];
         if (!in_frame[c] || since_last > gap_timeout) begin
            bits_in[c] = 0;
            frame_bits[c] = '0;
            first_bit_at[c] = ev.now_us;
            in_frame[c] = 1'b1;
         end
         if (bits_in[c] == 0)
            first_pulse[c] = pulse;
         if (ev.line_select)
            frame_bits[c][FRAME_BITS-1-bits_in[c]] = 1'b1;
         bits_in[c]++;
         last_bit_at[c] = ev.now_us;
         if (bits_in[c] == FRAME_BITS) begin
            rep.out_channel = ev.channel_index;
            rep.door = door_id[c];
            rep.tag = frame_bits[c][24:1];   // parity bits dropped
            rep.frame_time_us = last_bit_at[c] - first_bit_at[c] + first_pulse[c];
            pending_reports.push_back(rep);
            bits_in[c] = 0;
            in_frame[c] = 1'b0;
         end
      end
      seen_level[li] = ev.line_level;
   endtask

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, what, want, got);
         errors++;
      end
   endfunction

   // acceptance on both channels, sampled at the rising edge
   always @(posedge clock) begin
      card_report_type got, want;
      req_fired = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_fired = 1'b1;
            events_accepted++;
            decode_line_event(line_event_type'(req_tdata[35:0]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = card_report_type'(rsp_tdata[65:0]);
            if (pending_reports.size() == 0) begin
               $display("%0t: report expected none got %h", $time, got);
               errors++;
            end else begin
               want = pending_reports.pop_front();
               check_field("out_channel", 32'(want.out_channel), 32'(got.out_channel));
               check_field("door", 32'(want.door), 32'(got.door));
               check_field("tag", 32'(want.tag), 32'(got.tag));
               check_field("frame_time_us", want.frame_time_us, got.frame_time_us);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (req_idle > 0) begin
            req_idle--;
            req_tvalid <= 1'b0;
         end else if (line_events.size() > 0) begin
            req_tdata <= {4'b0, line_events.pop_front()};
            req_tvalid <= 1'b1;
            req_idle = idle_len(req_quiet);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold = idle_len(rsp_quiet);
      end
   end

   task automatic write_csr(input wmcr_pkg::csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         wmcr_pkg::CSR_GAP_TIMEOUT: gap_timeout = value;
         wmcr_pkg::CSR_DOOR_CH0:    door_id[0] = value[7:0];
         wmcr_pkg::CSR_DOOR_CH1:    door_id[1] = value[7:0];
         wmcr_pkg::CSR_DOOR_CH2:    door_id[2] = value[7:0];
         wmcr_pkg::CSR_DOOR_CH3:    door_id[3] = value[7:0];
         default: ;
      endcase
   endtask

   task automatic stage_event(input int c, input bit sel, input bit level, input logic [31:0] at);
      line_event_type ev;
      ev.channel_index = 2'(c);
      ev.line_select = sel;
      ev.line_level = level;
      ev.now_us = at;
      if (gen_level[2*c + sel] != level)
         phase_events++;
      gen_level[2*c + sel] = level;
      staged[c].push_back(ev);
   endtask

   // interleave the per-channel streams, keeping order within a channel
   task automatic merge_staged();
      int c;
      while (staged[0].size() + staged[1].size() + staged[2].size() + staged[3].size() > 0) begin
         c = $urandom_range(0, NUM_CHANNELS - 1);
         if (staged[c].size() > 0) begin
            line_events.push_back(staged[c].pop_front());
            events_queued++;
         end
      end
   endtask

   // One card read on channel c. A broken read is either cut short or has an
   // idle gap past the timeout somewhere in the middle.
   task automatic build_frame(input int c, input bit broken);
      logic [FRAME_BITS-1:0] bits;
      logic [31:0] t, d, p, span;
      int          nbits, cut;
      bit          sel;
      bits = FRAME_BITS'($urandom);
      nbits = FRAME_BITS;
      cut = -1;
      span = (gap_timeout < 32'd3000) ? gap_timeout : 32'd3000;
      if (broken) begin
         if ($urandom_range(0, 1) == 1 && gap_timeout < 32'h8000_0000)
            cut = $urandom_range(1, FRAME_BITS - 1);
         else
            nbits = $urandom_range(1, FRAME_BITS - 1);
      end
      t = gen_time[c];
      if (gap_timeout < 32'h8000_0000 && $urandom_range(0, 7) != 0)
         t = t + gap_timeout + 1 + $urandom_range(0, 50000);
      for (int i = 0; i < nbits; i++) begin
         d = $urandom_range(0, span);
         if (i == cut)
            d = gap_timeout + 1 + $urandom_range(0, 1000);
         p = $urandom_range(0, (d > span) ? span : d);
         sel = bits[FRAME_BITS-1-i];
         if (gen_level[2*c + sel])
            stage_event(c, sel, 1'b0, t + d - p);
         stage_event(c, sel, 1'b1, t + d);
         t = t + d;
      end
      gen_time[c] = t;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (events_accepted != events_queued || pending_reports.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   initial begin
      int          r;
      int          c;
      bit          sel;
      logic [3:0]  mask;
      logic [31:0] gap_val;
      logic [7:0]  door_vals[NUM_CHANNELS];

      reset_decoder();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle-high repeat, wrapped pulse, zero and full-range pulses,
      // a repeated low, and a bit arriving after the timeout
      stage_event(0, 0, 1'b1, 32'h0000_0000);
      stage_event(0, 0, 1'b0, 32'hFFFF_FFF0);
      stage_event(0, 0, 1'b0, 32'h0000_0005);
      stage_event(0, 0, 1'b1, 32'h0000_0010);
      stage_event(0, 1, 1'b0, 32'h0000_0020);
      stage_event(0, 1, 1'b1, 32'h0000_0030);
      stage_event(1, 1, 1'b0, 32'hFFFF_FFFF);
      stage_event(1, 1, 1'b1, 32'hFFFF_FFFF);
      stage_event(2, 1, 1'b0, 32'h0000_0000);
      stage_event(2, 1, 1'b1, 32'hFFFF_FFFF);
      stage_event(3, 0, 1'b0, 32'h5555_5555);
      stage_event(3, 0, 1'b1, 32'hAAAA_AAAA);
      stage_event(3, 1, 1'b1, 32'hAAAA_AAAA);
      stage_event(0, 0, 1'b0, 32'h0000_1000);
      stage_event(0, 0, 1'b1, 32'h8000_0000);
      stage_event(2, 0, 1'b0, 32'h0000_0000);
      stage_event(2, 0, 1'b1, 32'h0000_0000);
      merge_staged();

      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            wait_idle();
            case (ph)
               1: begin
                  gap_val = 32'd0;
                  door_vals = '{8'd0, 8'd255, 8'd0, 8'd255};
               end
               2: begin
                  gap_val = 32'hFFFF_FFFF;
                  door_vals = '{8'd255, 8'd0, 8'd255, 8'd0};
               end
               3: begin
                  gap_val = $urandom_range(500, 5000);
                  for (int i = 0; i < NUM_CHANNELS; i++) door_vals[i] = 8'($urandom);
               end
               default: begin
                  gap_val = $urandom;
                  for (int i = 0; i < NUM_CHANNELS; i++) door_vals[i] = 8'($urandom);
               end
            endcase
            write_csr(wmcr_pkg::CSR_GAP_TIMEOUT, gap_val);
            for (int i = 0; i < NUM_CHANNELS; i++)
               write_csr(wmcr_pkg::csr_index_type'(int'(wmcr_pkg::CSR_DOOR_CH0) + i),
                         {24'b0, door_vals[i]});
         end
         for (int i = 0; i < NUM_CHANNELS; i++)
            gen_time[i] = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 80000)
                                                      : $urandom;
         phase_events = 0;
         while (phase_events < PHASE_EVENTS) begin
            r = $urandom_range(0, 9);
            if (r < 6 || r == 9) begin
               mask = 4'($urandom_range(1, 15));
               for (int i = 0; i < NUM_CHANNELS; i++)
                  if (mask[i]) build_frame(i, 1'b0);
            end else if (r < 8) begin
               build_frame($urandom_range(0, NUM_CHANNELS - 1), 1'b1);
            end else begin
               // stray edges, random or close to the channel's own clock
               repeat ($urandom_range(1, 8)) begin
                  c = $urandom_range(0, NUM_CHANNELS - 1);
                  sel = 1'($urandom_range(0, 1));
                  if ($urandom_range(0, 3) == 0)
                     stage_event(c, sel, gen_level[2*c + sel], $urandom);
                  else if ($urandom_range(0, 1) == 0)
                     stage_event(c, sel, 1'($urandom_range(0, 1)), $urandom);
                  else
                     stage_event(c, sel, 1'($urandom_range(0, 1)),
                                 gen_time[c] + $urandom_range(0, 3000));
               end
            end
            merge_staged();
         end
      end

      wait_idle();

      if (errors == 0)
         $display("wiegand_multi_channel_receiver verification clean");
      else
         $display("wiegand_multi_channel_receiver verification failed");
      $finish;
   end

endmodule
